>>> sv/mdrt_pkg.sv
// shared types and codes for the module directory refcount table
package mdrt_pkg;

	// request codes
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_LINK   = 2'd1;
	localparam logic [1:0] REQ_UNLINK = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
	localparam logic [15:0] COUNT_ZERO = 16'h0000;
	localparam logic [15:0] COUNT_ONE  = 16'h0001;
	localparam logic [7:0]  BYTE_ANY   = 8'h00;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] header_address;
		logic [15:0] type_language;
		logic [15:0] attribute_revision;
		logic [63:0] module_name;
		logic        make_permanent;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_header;
		logic [15:0] link_count_after;
		logic        entry_removed;
	} rsp_t;

	typedef struct packed {
		logic [31:0] header;
		logic [15:0] type_language;
		logic [15:0] attribute_revision;
		logic [63:0] name;
		logic [15:0] link_count;
		logic        permanent;
		logic [15:0] age_stamp;
	} entry_t;

	// ranking of the best candidate so far
	typedef struct packed {
		logic        have;
		logic [7:0]  rev;
		logic [15:0] age;
	} score_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> sv/mdrt_ram.sv
// generic single write port, single read port ram with registered read
module mdrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/mdrt_eval.sv
// per-entry candidate test and ranking against the best entry so far
module mdrt_eval #(
	parameter int NAME_CHARS = 8
) (
	input  mdrt_pkg::req_t   req,
	input  mdrt_pkg::entry_t ent,
	input  logic             ent_valid,
	input  logic [15:0]      ins_cnt,
	input  mdrt_pkg::score_t best,
	output mdrt_pkg::score_t cand,
	output logic             take
);

	function automatic logic is_name_char(input logic [7:0] c);
		is_name_char = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || c == "_" || c == "." || c == "$";
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		fold = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
	endfunction

	logic       name_ok;
	logic [7:0] a_ch;
	logic [7:0] b_ch;
	logic       type_ok;
	logic       lang_ok;
	logic       better;

	// walk from the last position back so the first zero of the stored name wins
	always_comb begin
		name_ok = 1'b0;
		a_ch    = '0;
		b_ch    = '0;
		for (int i = NAME_CHARS - 1; i >= 0; i--) begin
			a_ch = ent.name[63 - 8 * i -: 8];
			b_ch = req.module_name[63 - 8 * i -: 8];
			if (a_ch == 8'h00) begin
				name_ok = !is_name_char(b_ch);
			end else if (fold(a_ch) != fold(b_ch)) begin
				name_ok = 1'b0;
			end
		end
	end

	always_comb begin
		type_ok = (req.type_language[15:8] == mdrt_pkg::BYTE_ANY) ||
			(req.type_language[15:8] == ent.type_language[15:8]);
		lang_ok = (req.type_language[7:0] == mdrt_pkg::BYTE_ANY) ||
			(req.type_language[7:0] == ent.type_language[7:0]);
		cand.have = 1'b1;
		cand.rev  = ent.attribute_revision[7:0];
		cand.age  = ins_cnt - ent.age_stamp;
		better    = 1'b0;
		take      = 1'b0;
		case (req.req_type)
			mdrt_pkg::REQ_ADD: begin
				take = !ent_valid && !best.have;
			end
			mdrt_pkg::REQ_LINK: begin
				better = !best.have || cand.rev > best.rev ||
					(cand.rev == best.rev && cand.age < best.age);
				take = ent_valid && type_ok && lang_ok && name_ok && better;
			end
			mdrt_pkg::REQ_UNLINK: begin
				better = !best.have || cand.age < best.age;
				take = ent_valid && ent.header == req.header_address && better;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

endmodule

>>> sv/module_directory_refcount_table_unit.sv
// module directory with link counts: scan sequencer around the entry memory
//
// a request is accepted when start is high and busy is low; busy then stays
// high while the table is scanned and the chosen entry is written back.
// one entry is read per cycle through the single read port of the entry
// memory, each read word is registered and ranked in the next cycle, and
// after the last entry has been ranked the write state
// writes the chosen entry back. the result appears on rsp for exactly one
// cycle with done high, and the receiver cannot hold it off, so it must
// capture rsp whenever done is seen. busy falls in the cycle in which done
// is shown, so the next item can be taken while the result is on the ports.
// add takes the lowest free entry, link ranks matching entries by revision
// and then by age, unlink picks the newest entry with the given header. the
// entry memory needs no clearing after reset: per-entry valid flops are
// cleared at once and an entry is only looked at when its valid bit is set
module module_directory_refcount_table_unit #(
	parameter int ENTRIES    = 32,
	parameter int NAME_CHARS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mdrt_pkg::req_t   req,
	output logic             busy,
	output logic             done,
	output mdrt_pkg::rsp_t   rsp
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE
	} state_t;

	// control state
	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               vld_s1;
	logic [ENTRIES-1:0] valid_q;
	logic [15:0]        ins_cnt_q;
	logic               have_q;
	logic               done_q;

	// payload
	mdrt_pkg::req_t     req_q;
	logic [IDX_W-1:0]   idx_s1;
	logic [IDX_W-1:0]   best_idx_q;
	logic [7:0]         best_rev_q;
	logic [15:0]        best_age_q;
	mdrt_pkg::entry_t   best_ent_q;
	mdrt_pkg::rsp_t     rsp_q;

	// memory side
	logic               ram_we;
	mdrt_pkg::entry_t   wr_ent;
	logic [mdrt_pkg::ENTRY_W-1:0] rd_word;
	mdrt_pkg::entry_t   rd_ent;

	// ranking
	mdrt_pkg::score_t   best_score;
	mdrt_pkg::score_t   cand_score;
	logic               cand_take;
	logic               take_s1;
	logic               scan_more;

	// write-back decisions
	mdrt_pkg::rsp_t     rsp_d;
	logic [15:0]        new_cnt;
	logic               add_ok;
	logic               free_entry;

	assign scan_more = cnt_q < CNT_W'(ENTRIES);
	assign rd_ent    = mdrt_pkg::entry_t'(rd_word);

	mdrt_ram #(
		.WIDTH(mdrt_pkg::ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(best_idx_q),
		.wdata(wr_ent),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(rd_word)
	);

	assign best_score = '{have: have_q, rev: best_rev_q, age: best_age_q};

	mdrt_eval #(
		.NAME_CHARS(NAME_CHARS)
	) u_eval (
		.req      (req_q),
		.ent      (rd_ent),
		.ent_valid(valid_q[idx_s1]),
		.ins_cnt  (ins_cnt_q),
		.best     (best_score),
		.cand     (cand_score),
		.take     (cand_take)
	);

	// the entry read last cycle is ranked only while the read stage is live
	assign take_s1 = vld_s1 && cand_take && state_q == S_SCAN;

	// result and write-back for the chosen entry
	always_comb begin
		wr_ent     = best_ent_q;
		new_cnt    = best_ent_q.link_count;
		add_ok     = 1'b0;
		free_entry = 1'b0;
		ram_we     = 1'b0;
		rsp_d      = '0;
		rsp_d.status = mdrt_pkg::ST_NOT_FOUND;
		case (req_q.req_type)
			mdrt_pkg::REQ_ADD: begin
				if (have_q) begin
					add_ok                    = 1'b1;
					ram_we                    = 1'b1;
					wr_ent.header             = req_q.header_address;
					wr_ent.type_language      = req_q.type_language;
					wr_ent.attribute_revision = req_q.attribute_revision;
					wr_ent.name               = req_q.module_name;
					wr_ent.link_count         = mdrt_pkg::COUNT_ZERO;
					wr_ent.permanent          = req_q.make_permanent;
					wr_ent.age_stamp          = ins_cnt_q;
					rsp_d.status              = mdrt_pkg::ST_OK;
				end else begin
					rsp_d.status = mdrt_pkg::ST_FULL;
				end
			end
			mdrt_pkg::REQ_LINK: begin
				if (have_q) begin
					// saturating increment
					if (best_ent_q.link_count != mdrt_pkg::COUNT_MAX) begin
						new_cnt = best_ent_q.link_count + mdrt_pkg::COUNT_ONE;
					end
					ram_we                 = 1'b1;
					wr_ent.link_count      = new_cnt;
					rsp_d.status           = mdrt_pkg::ST_OK;
					rsp_d.found_header     = best_ent_q.header;
					rsp_d.link_count_after = new_cnt;
				end
			end
			mdrt_pkg::REQ_UNLINK: begin
				if (have_q) begin
					// decrement floors at zero
					if (best_ent_q.link_count != mdrt_pkg::COUNT_ZERO) begin
						new_cnt = best_ent_q.link_count - mdrt_pkg::COUNT_ONE;
					end
					ram_we                 = 1'b1;
					wr_ent.link_count      = new_cnt;
					free_entry             = new_cnt == mdrt_pkg::COUNT_ZERO &&
						!best_ent_q.permanent;
					rsp_d.status           = mdrt_pkg::ST_OK;
					rsp_d.link_count_after = new_cnt;
					rsp_d.entry_removed    = free_entry;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		if (state_q != S_WRITE) begin
			ram_we = 1'b0;
		end
	end

	// sequencer, valid bits and insert counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			valid_q   <= '0;
			ins_cnt_q <= '0;
			have_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						vld_s1  <= 1'b0;
						have_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (take_s1) begin
						have_q <= 1'b1;
					end
					vld_s1 <= scan_more;
					if (scan_more) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (add_ok) begin
						valid_q[best_idx_q] <= 1'b1;
						ins_cnt_q           <= ins_cnt_q + 16'd1;
					end
					if (free_entry) begin
						valid_q[best_idx_q] <= 1'b0;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (take_s1) begin
			best_idx_q <= idx_s1;
			best_rev_q <= cand_score.rev;
			best_age_q <= cand_score.age;
			best_ent_q <= rd_ent;
		end
		if (state_q == S_WRITE) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

>>> sv/mdrt_checker.sv
// port-level checks for the module directory refcount table, bound to the top level
module mdrt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input mdrt_pkg::rsp_t rsp
);

	// an accepted item keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted but busy did not rise");

	// a result is never shown while an item is still being worked
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// one strobe per item, never two in a row
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// status is a known code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == mdrt_pkg::ST_OK || rsp.status == mdrt_pkg::ST_NOT_FOUND ||
			rsp.status == mdrt_pkg::ST_FULL))
		else $error("unknown status code");

	// a failed request reports nothing else
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != mdrt_pkg::ST_OK |->
			rsp.found_header == 32'd0 && rsp.link_count_after == 16'd0 &&
			!rsp.entry_removed)
		else $error("failed request with non-zero result fields");

endmodule

bind module_directory_refcount_table_unit mdrt_checker u_mdrt_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

>>> verif/module_directory_refcount_table_checker.sv
// checker for the module directory: predicts every answer and compares it with the dut
module module_directory_refcount_table_checker #(
	parameter int ENTRIES    = 32,
	parameter int NAME_CHARS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  mdrt_pkg::req_t req,
	input  logic           done,
	input  mdrt_pkg::rsp_t rsp,
	output int             errors,
	output int             pending
);
	import mdrt_pkg::*;

	logic        dir_valid [ENTRIES];
	entry_t      dir_entry [ENTRIES];
	logic [15:0] add_count;
	rsp_t        answers_due [$];
	rsp_t        oldest;
	int          fails;

	function automatic bit is_name_byte(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || c == "_" || c == "." || c == "$";
	endfunction

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
	endfunction

	// stored name ends at its first zero, the target must not go on with a name byte there
	function automatic bit name_hit(input logic [63:0] stored, input logic [63:0] target);
		logic [7:0] s;
		logic [7:0] t;
		for (int i = 0; i < NAME_CHARS && i < 8; i++) begin
			s = stored[63 - 8 * i -: 8];
			t = target[63 - 8 * i -: 8];
			if (s == 8'h00)
				return !is_name_byte(t);
			if (lower(s) != lower(t))
				return 1'b0;
		end
		return 1'b0;
	endfunction

	// applies one request to the shadow directory and returns its answer
	function automatic rsp_t answer_request(input req_t r);
		rsp_t        res;
		entry_t      slot;
		int          pick;
		logic [7:0]  want_type;
		logic [7:0]  want_lang;
		logic [7:0]  rev;
		logic [7:0]  best_rev;
		logic [15:0] age;
		logic [15:0] best_age;
		res = '0;
		res.status = ST_NOT_FOUND;
		pick = -1;
		best_rev = '0;
		best_age = '0;
		case (r.req_type)
		REQ_ADD: begin
			for (int e = 0; e < ENTRIES; e++)
				if (pick < 0 && !dir_valid[e])
					pick = e;
			if (pick < 0) begin
				res.status = ST_FULL;
			end else begin
				slot.header = r.header_address;
				slot.type_language = r.type_language;
				slot.attribute_revision = r.attribute_revision;
				slot.name = r.module_name;
				slot.link_count = COUNT_ZERO;
				slot.permanent = r.make_permanent;
				slot.age_stamp = add_count;
				dir_entry[pick] = slot;
				dir_valid[pick] = 1'b1;
				add_count = add_count + 16'd1;
				res.status = ST_OK;
			end
		end
		REQ_LINK: begin
			want_type = r.type_language[15:8];
			want_lang = r.type_language[7:0];
			for (int e = 0; e < ENTRIES; e++) begin
				slot = dir_entry[e];
				if (dir_valid[e] &&
						(want_type == BYTE_ANY || want_type == slot.type_language[15:8]) &&
						(want_lang == BYTE_ANY || want_lang == slot.type_language[7:0]) &&
						name_hit(slot.name, r.module_name)) begin
					rev = slot.attribute_revision[7:0];
					age = add_count - slot.age_stamp;
					if (pick < 0 || rev > best_rev || (rev == best_rev && age < best_age)) begin
						pick = e;
						best_rev = rev;
						best_age = age;
					end
				end
			end
			if (pick >= 0) begin
				slot = dir_entry[pick];
				if (slot.link_count != COUNT_MAX)
					slot.link_count = slot.link_count + COUNT_ONE;
				dir_entry[pick] = slot;
				res.status = ST_OK;
				res.found_header = slot.header;
				res.link_count_after = slot.link_count;
			end
		end
		REQ_UNLINK: begin
			for (int e = 0; e < ENTRIES; e++) begin
				slot = dir_entry[e];
				age = add_count - slot.age_stamp;
				if (dir_valid[e] && slot.header == r.header_address &&
						(pick < 0 || age < best_age)) begin
					pick = e;
					best_age = age;
				end
			end
			if (pick >= 0) begin
				slot = dir_entry[pick];
				if (slot.link_count != COUNT_ZERO)
					slot.link_count = slot.link_count - COUNT_ONE;
				dir_entry[pick] = slot;
				res.status = ST_OK;
				res.link_count_after = slot.link_count;
				if (slot.link_count == COUNT_ZERO && !slot.permanent) begin
					dir_valid[pick] = 1'b0;
					res.entry_removed = 1'b1;
				end
			end
		end
		default: begin
		end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < ENTRIES; e++)
				dir_valid[e] = 1'b0;
			add_count = '0;
			answers_due.delete();
			fails = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			// a result and the next item can share an edge: the result is older
			if (done) begin
				if (answers_due.size() == 0) begin
					$error("result with none awaited: status %0d", rsp.status);
					fails++;
				end else begin
					oldest = answers_due.pop_front();
					if (rsp.status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, rsp.status);
						fails++;
					end
					if (rsp.found_header !== oldest.found_header) begin
						$error("found_header: expected %h, got %h",
							oldest.found_header, rsp.found_header);
						fails++;
					end
					if (rsp.link_count_after !== oldest.link_count_after) begin
						$error("link_count_after: expected %0d, got %0d",
							oldest.link_count_after, rsp.link_count_after);
						fails++;
					end
					if (rsp.entry_removed !== oldest.entry_removed) begin
						$error("entry_removed: expected %0d, got %0d",
							oldest.entry_removed, rsp.entry_removed);
						fails++;
					end
				end
			end
			if (start && !busy)
				answers_due.push_back(answer_request(req));
			errors <= fails;
			pending <= answers_due.size();
		end
	end

endmodule

>>> verif/module_directory_refcount_table_unit_tb.sv
// testbench top: request stimulus for the module directory refcount table and the verdict
module module_directory_refcount_table_unit_tb;
	import mdrt_pkg::*;

	localparam int ENTRIES    = 32;
	localparam int NAME_CHARS = 8;
	localparam int STEMS      = 11;
	localparam int BLOCKS     = 15;
	localparam int BLOCK_LEN  = 100;

	// the one request code the package leaves unnamed, answered as not found
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// request mixes for the random blocks
	localparam int MIX_EVEN  = 0;
	localparam int MIX_FILL  = 1;
	localparam int MIX_DRAIN = 2;

	logic        clk;
	logic        arst_n;
	logic        start;
	req_t        req;
	logic        busy;
	logic        done;
	rsp_t        rsp;
	int          errors;
	int          pending;
	logic [31:0] hdr_pool [16];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	module_directory_refcount_table_unit #(
		.ENTRIES    (ENTRIES),
		.NAME_CHARS (NAME_CHARS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	module_directory_refcount_table_checker #(
		.ENTRIES    (ENTRIES),
		.NAME_CHARS (NAME_CHARS)
	) i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	// names that entries are added under; the eight-byte one has no terminator
	// and so can never be linked, the empty one matches any non-name byte
	function automatic logic [63:0] stem_at(input int i);
		case (i)
		0:       return {"init", 32'd0};
		1:       return {"cio", 40'd0};
		2:       return {"Math", 32'd0};
		3:       return {"sysgo", 24'd0};
		4:       return {"shell", 24'd0};
		5:       return {"ab_1.$", 16'd0};
		6:       return {"fmgr7", 24'd0};
		7:       return "scf_desc";
		8:       return 64'd0;
		9:       return {"x", 56'd0};
		default: return {"Z@[", 40'd0};
		endcase
	endfunction

	// flip the case of letters at random, other bytes untouched
	function automatic logic [63:0] mix_case(input logic [63:0] name);
		logic [63:0] out;
		logic [7:0]  c;
		out = name;
		for (int i = 0; i < 8; i++) begin
			c = name[63 - 8 * i -: 8];
			if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
				out[63 - 8 * i -: 8] = c ^ 8'h20;
		end
		return out;
	endfunction

	// link target built from a stored name: the byte after the name is mostly
	// a terminator, sometimes a name byte that spoils the match, and the tail
	// beyond it is junk that must be ignored
	function automatic logic [63:0] link_name(input logic [63:0] stem);
		logic [63:0] t;
		int          cut;
		t = mix_case(stem);
		cut = 8;
		for (int i = 7; i >= 0; i--)
			if (stem[63 - 8 * i -: 8] == 8'h00)
				cut = i;
		if (cut < 8) begin
			case ($urandom_range(0, 5))
			0:       t[63 - 8 * cut -: 8] = 8'h00;
			1:       t[63 - 8 * cut -: 8] = " ";
			2:       t[63 - 8 * cut -: 8] = "/";
			3:       t[63 - 8 * cut -: 8] = "_";
			default: t[63 - 8 * cut -: 8] = 8'($urandom_range(0, 255));
			endcase
			for (int i = cut + 1; i < 8; i++)
				t[63 - 8 * i -: 8] = 8'($urandom_range(0, 255));
		end
		// now and then a stray byte anywhere
		if ($urandom_range(0, 9) == 0)
			t[63 - 8 * $urandom_range(0, 7) -: 8] = 8'($urandom_range(0, 255));
		return t;
	endfunction

	function automatic logic [31:0] pick_header();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return hdr_pool[$urandom_range(0, 15)];
	endfunction

	// every field random, request code included
	function automatic req_t random_req();
		req_t r;
		r.req_type = 2'($urandom_range(0, 3));
		r.header_address = $urandom;
		r.type_language = 16'($urandom_range(0, 65535));
		r.attribute_revision = 16'($urandom_range(0, 65535));
		r.module_name = {$urandom, $urandom};
		r.make_permanent = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic req_t make_req(input logic [1:0] kind, input logic [31:0] hdr,
			input logic [15:0] tl, input logic [15:0] ar, input logic [63:0] name,
			input logic perm);
		req_t r;
		r.req_type = kind;
		r.header_address = hdr;
		r.type_language = tl;
		r.attribute_revision = ar;
		r.module_name = name;
		r.make_permanent = perm;
		return r;
	endfunction

	// well-formed requests on a small set of names, headers, types and
	// revisions, so that links hit, revisions tie and headers repeat;
	// a few percent stay pure noise
	function automatic req_t draw_request(input int mix);
		req_t        r;
		int          roll;
		int          add_w;
		int          link_w;
		logic [63:0] stem;
		r = random_req();
		if ($urandom_range(0, 99) < 5)
			return r;
		case (mix)
		MIX_FILL: begin
			add_w = 70;
			link_w = 20;
		end
		MIX_DRAIN: begin
			add_w = 10;
			link_w = 20;
		end
		default: begin
			add_w = 35;
			link_w = 35;
		end
		endcase
		roll = $urandom_range(0, 99);
		stem = stem_at($urandom_range(0, STEMS - 1));
		if (roll < add_w) begin
			r.req_type = REQ_ADD;
			r.header_address = pick_header();
			if ($urandom_range(0, 9) != 0) begin
				r.type_language[15:8] = 8'($urandom_range(1, 3));
				r.type_language[7:0] = 8'($urandom_range(1, 2));
				r.attribute_revision[7:0] = 8'($urandom_range(0, 3));
			end
			if ($urandom_range(0, 19) != 0)
				r.module_name = mix_case(stem);
			// permanent entries never leave, so keep them rare
			r.make_permanent = ($urandom_range(0, 49) == 0);
		end else if (roll < add_w + link_w) begin
			r.req_type = REQ_LINK;
			if ($urandom_range(0, 19) != 0) begin
				r.type_language[15:8] = $urandom_range(0, 1) ? BYTE_ANY :
					8'($urandom_range(1, 3));
				r.type_language[7:0] = $urandom_range(0, 1) ? BYTE_ANY :
					8'($urandom_range(1, 2));
				r.module_name = link_name(stem);
			end
		end else begin
			r.req_type = REQ_UNLINK;
			r.header_address = pick_header();
		end
		return r;
	endfunction

	// mostly back to back or short gaps, now and then a long one
	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 40);
		return $urandom_range(41, 120);
	endfunction

	// offer one item and hold it until taken; start stays high when the
	// next item follows at once, and junk sits on req while idle
	task automatic issue(input req_t item, input bit idle_ok);
		int gap;
		start <= 1'b1;
		req <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		gap = idle_ok ? gap_len() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			req <= random_req();
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every awaited result is back
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int mix;
		bit quiet;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		hdr_pool[0] = 32'h0000_0000;
		hdr_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 16; i++)
			hdr_pool[i] = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, unknown code, revision and age ties,
		// filters, name ends, floors, permanence and removal
		issue(make_req(REQ_LINK, 32'h0, 16'h0, 16'h0, {"init", 32'd0}, 1'b0), 1'b1);
		issue(make_req(REQ_UNLINK, 32'hFFFF_FFFF, 16'h0, 16'h0, 64'd0, 1'b0), 1'b1);
		issue(make_req(REQ_UNKNOWN, 32'h0, 16'h0101, 16'h0, {"init", 32'd0}, 1'b1), 1'b1);
		issue(make_req(REQ_ADD, 32'h0, 16'h0101, 16'h0001, {"init", 32'd0}, 1'b0), 1'b1);
		issue(make_req(REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, {"INIT", 32'd0}, 1'b1),
			1'b1);
		issue(make_req(REQ_ADD, 32'h1000, 16'h0101, 16'h0001, {"Init", 32'd0}, 1'b0), 1'b1);
		// highest revision wins regardless of age
		issue(make_req(REQ_LINK, 32'h0, 16'h0000, 16'h0, {"init", 32'd0}, 1'b0), 1'b1);
		// equal revisions under the filter: the newer entry wins
		issue(make_req(REQ_LINK, 32'h0, 16'h0101, 16'h0, {"iNiT", 32'd0}, 1'b0), 1'b1);
		issue(make_req(REQ_LINK, 32'h0, 16'h0100, 16'h0, {"init", " ", 24'hFFFFFF}, 1'b0),
			1'b1);
		// target goes on with a name byte, then one that stops short
		issue(make_req(REQ_LINK, 32'h0, 16'h0000, 16'h0, {"initx", 24'd0}, 1'b0), 1'b1);
		issue(make_req(REQ_LINK, 32'h0, 16'h0000, 16'h0, {"ini", 40'd0}, 1'b0), 1'b1);
		// full-length stored name has no end and cannot match
		issue(make_req(REQ_ADD, 32'h2000, 16'h0201, 16'h0005, "abcdefgh", 1'b0), 1'b1);
		issue(make_req(REQ_LINK, 32'h0, 16'h0000, 16'h0, "abcdefgh", 1'b0), 1'b1);
		// empty stored name
		issue(make_req(REQ_ADD, 32'h3000, 16'h0302, 16'h0000, 64'd0, 1'b0), 1'b1);
		issue(make_req(REQ_LINK, 32'h0, 16'h0302, 16'h0, 64'd0, 1'b0), 1'b1);
		issue(make_req(REQ_LINK, 32'h0, 16'h0000, 16'h0, {"/", 56'd0}, 1'b0), 1'b1);
		// permanent entry drops to zero and stays, count floors
		issue(make_req(REQ_UNLINK, 32'hFFFF_FFFF, 16'h0, 16'h0, 64'd0, 1'b0), 1'b1);
		issue(make_req(REQ_UNLINK, 32'hFFFF_FFFF, 16'h0, 16'h0, 64'd0, 1'b0), 1'b1);
		// ordinary entry counts down and is freed, then gone
		issue(make_req(REQ_UNLINK, 32'h1000, 16'h0, 16'h0, 64'd0, 1'b0), 1'b1);
		issue(make_req(REQ_UNLINK, 32'h1000, 16'h0, 16'h0, 64'd0, 1'b0), 1'b1);
		issue(make_req(REQ_UNLINK, 32'h1000, 16'h0, 16'h0, 64'd0, 1'b0), 1'b1);
		issue(make_req(REQ_UNLINK, 32'h0, 16'h0, 16'h0, 64'd0, 1'b0), 1'b1);
		// all ones everywhere
		issue(make_req(REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1), 1'b1);
		issue(make_req(REQ_LINK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1), 1'b1);
		settle();

		// random blocks: even mix, weighted towards adds, or
		// draining; some blocks run without idling
		for (int blk = 0; blk < BLOCKS; blk++) begin
			mix = $urandom_range(MIX_EVEN, MIX_DRAIN);
			quiet = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < BLOCK_LEN; n++)
				issue(draw_request(mix), !quiet);
			if ($urandom_range(0, 2) == 0)
				settle();
		end

		settle();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("module_directory_refcount_table_unit_tb: clean");
		else
			$display("module_directory_refcount_table_unit_tb: errors");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("module_directory_refcount_table_unit_tb: errors");
		$finish;
	end

endmodule

>>> filelist.f
sv/mdrt_pkg.sv
sv/mdrt_ram.sv
sv/mdrt_eval.sv
sv/module_directory_refcount_table_unit.sv
sv/mdrt_checker.sv
verif/module_directory_refcount_table_checker.sv
verif/module_directory_refcount_table_unit_tb.sv
